### rtl/irm_pkg.sv
// Shared types and constants for the I2C register read master.
// Used by irm_step and i2c_register_read_master; no dependencies.
`default_nettype none

package irm_pkg;

  localparam int unsigned ADDR_W     = 7;
  localparam int unsigned PLEN_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned BIT_CNT_W  = 4;
  localparam int unsigned BYTE_CNT_W = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ADDR_W-1:0]    DEV_ADDR_RST  = 7'd72;
  localparam logic [PLEN_W-1:0]    PHASE_LEN_RST = 16'd1;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LEN = 1'b1;

  // Transaction progress held in byte_cnt
  localparam logic [BYTE_CNT_W-1:0] BC_ADDR_WR = 3'd0;
  localparam logic [BYTE_CNT_W-1:0] BC_INDEX   = 3'd1;
  localparam logic [BYTE_CNT_W-1:0] BC_ADDR_RD = 3'd2;
  localparam logic [BYTE_CNT_W-1:0] BC_DATA_HI = 3'd3;
  localparam logic [BYTE_CNT_W-1:0] BC_DATA_LO = 3'd4;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_STA_A   = 5'd1,
    PH_STA_B   = 5'd2,
    PH_WR_LO   = 5'd3,
    PH_WR_HI   = 5'd4,
    PH_WACK_LO = 5'd5,
    PH_WACK_HI = 5'd6,
    PH_RD_LO   = 5'd7,
    PH_RD_HI   = 5'd8,
    PH_MACK_LO = 5'd9,
    PH_MACK_HI = 5'd10,
    PH_STO_A   = 5'd11,
    PH_STO_B   = 5'd12,
    PH_STO_C   = 5'd13
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [BIT_CNT_W-1:0]    bit_cnt;
    logic [BYTE_CNT_W-1:0]   byte_cnt;
    logic [BYTE_W-1:0]       shift;
    logic [WORD_W-1:0]       accum;
    logic [PLEN_W-1:0]       tick;
    logic [BYTE_W-1:0]       ptr;
    logic                    nack;
    logic                    scl;
    logic                    sda;
  } seq_state_t;

  localparam seq_state_t SEQ_RST = '{
    phase:    PH_IDLE,
    bit_cnt:  '0,
    byte_cnt: '0,
    shift:    '0,
    accum:    '0,
    tick:     '0,
    ptr:      '0,
    nack:     1'b0,
    scl:      1'b1,
    sda:      1'b1
  };

endpackage

`default_nettype wire

### rtl/i2c_register_read_master.sv
// I2C register read master: each result beat is registered and shows in the cycle after
// its item is accepted. Throughput 1 item per cycle unless the output stalls; the
// sequencer state and the result register both update at the edge that accepts an item,
// and a waiting result does not block input while it is being taken. Synchronous
// active-low reset returns the sequencer to idle with SCL and SDA released, device
// address 72 and phase length 1. Depends on irm_pkg and irm_step.
`default_nettype none

module i2c_register_read_master (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [7:0]                    in_register_index,
  input  wire logic                          in_sda_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_scl_level,
  output logic                               out_sda_release,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic [15:0]                        out_read_data,
  output logic                               out_ack_missing,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [irm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [irm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irm_pkg::*;

  seq_state_t        st_r;
  seq_state_t        st_nxt;
  logic              fin_nxt;
  logic [ADDR_W-1:0] dev_addr_r;
  logic [PLEN_W-1:0] phase_len_r;
  logic              out_valid_r;
  logic              scl_r;
  logic              sda_r;
  logic              busy_r;
  logic              done_r;
  logic [WORD_W-1:0] data_r;
  logic              ack_r;
  logic              in_acc;

  // Take a new item whenever the result slot is empty or drains this cycle
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  irm_step u_step (
    .cur_i       (st_r),
    .action_i    (in_action),
    .index_i     (in_register_index),
    .sda_i       (in_sda_in),
    .dev_addr_i  (dev_addr_r),
    .phase_len_i (phase_len_r),
    .nxt_o       (st_nxt),
    .fin_o       (fin_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= SEQ_RST;
      dev_addr_r  <= DEV_ADDR_RST;
      phase_len_r <= PHASE_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DEV_ADDR:  dev_addr_r  <= cfg_data[ADDR_W-1:0];
          CFG_PHASE_LEN: phase_len_r <= cfg_data[PLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload: load with the accepted item, hold while stalled
  always_ff @(posedge clk) begin
    if (in_acc) begin
      scl_r  <= st_nxt.scl;
      sda_r  <= st_nxt.sda;
      busy_r <= (st_nxt.phase != PH_IDLE);
      done_r <= fin_nxt;
      data_r <= st_nxt.accum;
      ack_r  <= st_nxt.nack;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_level   = scl_r;
  assign out_sda_release = sda_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_read_data   = data_r;
  assign out_ack_missing = ack_r;

  // The final STOP leaves the bus released and the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (scl_r && sda_r && !busy_r))
    else $error("done beat without released, idle bus");

  // A start from idle begins with SDA low under high SCL and clean status
  a_start_cond: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_START) && (st_r.phase == PH_IDLE))
      |=> (busy_r && scl_r && !sda_r && !ack_r && (data_r == '0)))
    else $error("start beat did not open a transaction");

  // A tick while idle changes no sequencer state
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_TICK) && (st_r.phase == PH_IDLE))
      |=> (st_r == $past(st_r)))
    else $error("idle tick moved the sequencer");

  // Busy result reflects the sequencer state it was taken from
  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (busy_r == (st_r.phase != PH_IDLE)))
    else $error("busy flag out of step with sequencer");

endmodule

`default_nettype wire

### rtl/irm_step.sv
// Next-state logic of the bus sequencer: one item (tick or start) per call.
// Depends on irm_pkg for the phase codes and the state struct.
`default_nettype none

module irm_step (
  input  wire irm_pkg::seq_state_t      cur_i,
  input  wire logic                     action_i,
  input  wire logic [irm_pkg::BYTE_W-1:0] index_i,
  input  wire logic                     sda_i,
  input  wire logic [irm_pkg::ADDR_W-1:0] dev_addr_i,
  input  wire logic [irm_pkg::PLEN_W-1:0] phase_len_i,
  output irm_pkg::seq_state_t           nxt_o,
  output logic                          fin_o
);
  import irm_pkg::*;

  seq_state_t        st;
  seq_state_t        adv;
  logic              adv_fin;
  logic [PLEN_W-1:0] len;
  logic [PLEN_W:0]   cnt;
  logic [BIT_CNT_W-1:0] bit_inc;
  logic [BYTE_W-1:0] shift_up;
  logic [BYTE_W-1:0] addr_byte;

  // Codes past the last stop phase fall back to idle
  always_comb begin
    st = cur_i;
    if (cur_i.phase > PH_STO_C) begin
      st.phase = PH_IDLE;
      st.scl   = 1'b1;
      st.sda   = 1'b1;
    end
  end

  assign bit_inc   = st.bit_cnt + BIT_CNT_W'(1);
  assign shift_up  = {st.shift[BYTE_W-2:0], 1'b0};
  assign addr_byte = {dev_addr_i, (st.byte_cnt == BC_ADDR_RD)};

  // Phase transition taken when the current phase runs out
  always_comb begin
    adv     = st;
    adv_fin = 1'b0;
    adv.tick = '0;
    unique case (st.phase)
      PH_STA_A: begin
        adv.phase = PH_STA_B; adv.scl = 1'b0; adv.sda = 1'b0;
      end
      PH_STA_B: begin
        adv.shift   = addr_byte;
        adv.bit_cnt = '0;
        adv.phase   = PH_WR_LO; adv.scl = 1'b0; adv.sda = addr_byte[BYTE_W-1];
      end
      PH_WR_LO: begin
        adv.phase = PH_WR_HI; adv.scl = 1'b1;
      end
      PH_WR_HI: begin
        adv.bit_cnt = bit_inc;
        if (bit_inc >= BITS_PER_BYTE) begin
          adv.phase = PH_WACK_LO; adv.scl = 1'b0; adv.sda = 1'b1;
        end else begin
          adv.shift = shift_up;
          adv.phase = PH_WR_LO; adv.scl = 1'b0; adv.sda = shift_up[BYTE_W-1];
        end
      end
      PH_WACK_LO: begin
        adv.phase = PH_WACK_HI; adv.scl = 1'b1; adv.sda = 1'b1;
      end
      PH_WACK_HI: begin
        adv.nack    = st.nack | sda_i;
        adv.bit_cnt = '0;
        if (st.byte_cnt == BC_ADDR_WR) begin
          adv.byte_cnt = BC_INDEX;
          adv.shift    = st.ptr;
          adv.phase    = PH_WR_LO; adv.scl = 1'b0; adv.sda = st.ptr[BYTE_W-1];
        end else if (st.byte_cnt == BC_INDEX) begin
          adv.phase = PH_STO_A; adv.scl = 1'b0; adv.sda = 1'b0;
        end else begin
          adv.byte_cnt = BC_DATA_HI;
          adv.phase    = PH_RD_LO; adv.scl = 1'b0; adv.sda = 1'b1;
        end
      end
      PH_RD_LO: begin
        adv.phase = PH_RD_HI; adv.scl = 1'b1; adv.sda = 1'b1;
      end
      PH_RD_HI: begin
        adv.accum   = {st.accum[WORD_W-2:0], sda_i};
        adv.bit_cnt = bit_inc;
        if (bit_inc >= BITS_PER_BYTE) begin
          // ACK the first data byte, NACK the last
          adv.phase = PH_MACK_LO; adv.scl = 1'b0;
          adv.sda   = (st.byte_cnt != BC_DATA_HI);
        end else begin
          adv.phase = PH_RD_LO; adv.scl = 1'b0; adv.sda = 1'b1;
        end
      end
      PH_MACK_LO: begin
        adv.phase = PH_MACK_HI; adv.scl = 1'b1;
      end
      PH_MACK_HI: begin
        if (st.byte_cnt == BC_DATA_HI) begin
          adv.byte_cnt = BC_DATA_LO;
          adv.bit_cnt  = '0;
          adv.phase    = PH_RD_LO; adv.scl = 1'b0; adv.sda = 1'b1;
        end else begin
          adv.phase = PH_STO_A; adv.scl = 1'b0; adv.sda = 1'b0;
        end
      end
      PH_STO_A: begin
        adv.phase = PH_STO_B; adv.scl = 1'b1; adv.sda = 1'b0;
      end
      PH_STO_B: begin
        adv.phase = PH_STO_C; adv.scl = 1'b1; adv.sda = 1'b1;
      end
      PH_STO_C: begin
        if (st.byte_cnt == BC_INDEX) begin
          adv.byte_cnt = BC_ADDR_RD;
          adv.phase    = PH_STA_A; adv.scl = 1'b1; adv.sda = 1'b0;
        end else begin
          adv.phase = PH_IDLE; adv.scl = 1'b1; adv.sda = 1'b1;
          adv_fin   = 1'b1;
        end
      end
      default: begin
        adv.phase = PH_IDLE; adv.scl = 1'b1; adv.sda = 1'b1;
      end
    endcase
  end

  assign len = (phase_len_i == '0) ? PLEN_W'(1) : phase_len_i;
  assign cnt = {1'b0, st.tick} + (PLEN_W+1)'(1);

  always_comb begin
    nxt_o = st;
    fin_o = 1'b0;
    if (action_i == ACT_START) begin
      if (st.phase == PH_IDLE) begin
        nxt_o.ptr      = index_i;
        nxt_o.byte_cnt = BC_ADDR_WR;
        nxt_o.bit_cnt  = '0;
        nxt_o.accum    = '0;
        nxt_o.nack     = 1'b0;
        nxt_o.tick     = '0;
        nxt_o.phase    = PH_STA_A;
        nxt_o.scl      = 1'b1;
        nxt_o.sda      = 1'b0;
      end
    end else if (st.phase != PH_IDLE) begin
      if (cnt >= {1'b0, len}) begin
        nxt_o = adv;
        fin_o = adv_fin;
      end else begin
        nxt_o.tick = cnt[PLEN_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking bench for i2c_register_read_master: queued bus items feed a clocked driver,
// a clocked monitor predicts each result beat and compares it with the block's output.
// Depends on irm_pkg and the RTL of i2c_register_read_master.
`default_nettype none

module tb;
  import irm_pkg::*;

  typedef struct packed {
    logic       action;
    logic [7:0] index;
    logic       sda;
  } bus_item_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        busy;
    logic        done;
    logic [15:0] data;
    logic        nack;
  } bus_res_t;

  typedef enum int unsigned {SDA_LOW, SDA_HIGH, SDA_SPARSE, SDA_COIN} sda_mode_t;
  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = ACT_TICK;
  logic [7:0]            in_register_index = 8'h00;
  logic                  in_sda_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_scl_level;
  logic                  out_sda_release;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic [15:0]           out_read_data;
  logic                  out_ack_missing;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEV_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  i2c_register_read_master u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_register_index (in_register_index),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl_level     (out_scl_level),
    .out_sda_release   (out_sda_release),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_read_data     (out_read_data),
    .out_ack_missing   (out_ack_missing),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sequencer copy used for prediction
  logic [ADDR_W-1:0]     cfg_addr  = DEV_ADDR_RST;
  logic [PLEN_W-1:0]     cfg_plen  = PHASE_LEN_RST;
  phase_t                seq_phase = PH_IDLE;
  logic [BIT_CNT_W-1:0]  bit_no    = '0;
  logic [BYTE_CNT_W-1:0] byte_no   = '0;
  logic [BYTE_W-1:0]     sh_byte   = '0;
  logic [WORD_W-1:0]     rd_word   = '0;
  logic [PLEN_W-1:0]     tick_cnt  = '0;
  logic [BYTE_W-1:0]     idx_hold  = '0;
  logic                  nack_seen = 1'b0;
  logic                  scl_q     = 1'b1;
  logic                  sda_q     = 1'b1;

  bus_item_t   pending_q[$];
  bus_res_t    res_q[$];
  int unsigned err_cnt    = 0;
  bit          in_taken   = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned stall_cyc  = 0;
  stall_mode_t stall_mode = STALL_NONE;

  function automatic bus_res_t step_bus(input logic action, input logic [7:0] idx,
                                        input logic sda);
    bus_res_t             r;
    logic                 fin;
    logic [PLEN_W-1:0]    plen;
    logic [PLEN_W:0]      cnt;
    fin = 1'b0;
    if (action == ACT_START) begin
      if (seq_phase == PH_IDLE) begin
        idx_hold = idx;
        byte_no = BC_ADDR_WR;
        bit_no = '0;
        rd_word = '0;
        nack_seen = 1'b0;
        tick_cnt = '0;
        seq_phase = PH_STA_A;
        {scl_q, sda_q} = 2'b10;
      end
    end else if (seq_phase != PH_IDLE) begin
      plen = (cfg_plen == '0) ? PLEN_W'(1) : cfg_plen;
      cnt = {1'b0, tick_cnt} + (PLEN_W+1)'(1);
      if (cnt >= {1'b0, plen}) begin
        tick_cnt = '0;
        // end of the current bus phase
        case (seq_phase)
          PH_STA_A: begin
            seq_phase = PH_STA_B;
            {scl_q, sda_q} = 2'b00;
          end
          PH_STA_B: begin
            sh_byte = {cfg_addr, (byte_no == BC_ADDR_RD)};
            bit_no = '0;
            seq_phase = PH_WR_LO;
            {scl_q, sda_q} = {1'b0, sh_byte[7]};
          end
          PH_WR_LO: begin
            seq_phase = PH_WR_HI;
            scl_q = 1'b1;
          end
          PH_WR_HI: begin
            bit_no = bit_no + BIT_CNT_W'(1);
            if (bit_no >= BITS_PER_BYTE) begin
              seq_phase = PH_WACK_LO;
              {scl_q, sda_q} = 2'b01;
            end else begin
              sh_byte = sh_byte << 1;
              seq_phase = PH_WR_LO;
              {scl_q, sda_q} = {1'b0, sh_byte[7]};
            end
          end
          PH_WACK_LO: begin
            seq_phase = PH_WACK_HI;
            {scl_q, sda_q} = 2'b11;
          end
          PH_WACK_HI: begin
            if (sda) nack_seen = 1'b1;
            bit_no = '0;
            if (byte_no == BC_ADDR_WR) begin
              byte_no = BC_INDEX;
              sh_byte = idx_hold;
              seq_phase = PH_WR_LO;
              {scl_q, sda_q} = {1'b0, sh_byte[7]};
            end else if (byte_no == BC_INDEX) begin
              seq_phase = PH_STO_A;
              {scl_q, sda_q} = 2'b00;
            end else begin
              byte_no = BC_DATA_HI;
              seq_phase = PH_RD_LO;
              {scl_q, sda_q} = 2'b01;
            end
          end
          PH_RD_LO: begin
            seq_phase = PH_RD_HI;
            {scl_q, sda_q} = 2'b11;
          end
          PH_RD_HI: begin
            rd_word = {rd_word[WORD_W-2:0], sda};
            bit_no = bit_no + BIT_CNT_W'(1);
            if (bit_no >= BITS_PER_BYTE) begin
              // ACK the first data byte, NACK the last
              seq_phase = PH_MACK_LO;
              {scl_q, sda_q} = {1'b0, (byte_no != BC_DATA_HI)};
            end else begin
              seq_phase = PH_RD_LO;
              {scl_q, sda_q} = 2'b01;
            end
          end
          PH_MACK_LO: begin
            seq_phase = PH_MACK_HI;
            scl_q = 1'b1;
          end
          PH_MACK_HI: begin
            if (byte_no == BC_DATA_HI) begin
              byte_no = BC_DATA_LO;
              bit_no = '0;
              seq_phase = PH_RD_LO;
              {scl_q, sda_q} = 2'b01;
            end else begin
              seq_phase = PH_STO_A;
              {scl_q, sda_q} = 2'b00;
            end
          end
          PH_STO_A: begin
            seq_phase = PH_STO_B;
            {scl_q, sda_q} = 2'b10;
          end
          PH_STO_B: begin
            seq_phase = PH_STO_C;
            {scl_q, sda_q} = 2'b11;
          end
          PH_STO_C: begin
            if (byte_no == BC_INDEX) begin
              byte_no = BC_ADDR_RD;
              seq_phase = PH_STA_A;
              {scl_q, sda_q} = 2'b10;
            end else begin
              seq_phase = PH_IDLE;
              {scl_q, sda_q} = 2'b11;
              fin = 1'b1;
            end
          end
          default: begin
            seq_phase = PH_IDLE;
            {scl_q, sda_q} = 2'b11;
          end
        endcase
      end else begin
        tick_cnt = cnt[PLEN_W-1:0];
      end
    end
    r.scl  = scl_q;
    r.sda  = sda_q;
    r.busy = (seq_phase != PH_IDLE);
    r.done = fin;
    r.data = rd_word;
    r.nack = nack_seen;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      if (err_cnt < 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // Monitor: check the result beat first, then predict from the input beat
  always @(posedge clk) begin : monitor
    bus_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (res_q.size() == 0) begin
          if (err_cnt < 40)
            $display("%0t: result beat with nothing expected, expected none, actual %0h",
                     $time, {out_scl_level, out_sda_release, out_busy_res, out_done_res,
                             out_read_data, out_ack_missing});
          err_cnt++;
        end else begin
          want = res_q.pop_front();
          check_field("scl_level",   16'(want.scl),  16'(out_scl_level));
          check_field("sda_release", 16'(want.sda),  16'(out_sda_release));
          check_field("busy_res",    16'(want.busy), 16'(out_busy_res));
          check_field("done_res",    16'(want.done), 16'(out_done_res));
          check_field("read_data",   want.data,      out_read_data);
          check_field("ack_missing", 16'(want.nack), 16'(out_ack_missing));
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        res_q.push_back(step_bus(in_action, in_register_index, in_sda_in));
      end
    end
  end

  // Driver: bursts of beats with random gaps; hold the payload while stalled
  always @(negedge clk) begin : driver
    bus_item_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        in_valid          <= 1'b1;
        in_action         <= nxt.action;
        in_register_index <= nxt.index;
        in_sda_in         <= nxt.sda;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin : stall_gen
    stall_cyc++;
    if (stall_cyc % 97 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_cyc % 3 == 0);
      default:        out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic push_item(input logic action, input logic [7:0] idx, input logic sda);
    bus_item_t it;
    it.action = action;
    it.index  = idx;
    it.sda    = sda;
    pending_q.push_back(it);
  endtask

  // One full register read: start, enough ticks for every phase, then a few idle ticks
  task automatic queue_transfer(input logic [7:0] idx, input int unsigned plen_eff,
                                input sda_mode_t mode, input bit dup_start);
    logic s;
    push_item(ACT_START, idx, 1'($urandom_range(0, 1)));
    if (dup_start) push_item(ACT_START, ~idx, 1'($urandom_range(0, 1)));
    for (int unsigned i = 0; i < 100 * plen_eff; i++) begin
      // stray start while busy, to be ignored
      if ($urandom_range(0, 49) == 0)
        push_item(ACT_START, 8'($urandom_range(0, 255)), 1'b0);
      case (mode)
        SDA_LOW:    s = 1'b0;
        SDA_HIGH:   s = 1'b1;
        SDA_SPARSE: s = ($urandom_range(0, 7) == 0);
        default:    s = 1'($urandom_range(0, 1));
      endcase
      push_item(ACT_TICK, 8'($urandom_range(0, 255)), s);
    end
    repeat ($urandom_range(1, 4)) push_item(ACT_TICK, 8'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || res_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DEV_ADDR) cfg_addr = val[ADDR_W-1:0];
    else cfg_plen = val[PLEN_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] junk;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle ticks, a read that sees no ACK and all-ones data, then one with all zeros
    push_item(ACT_TICK, 8'h00, 1'b0);
    push_item(ACT_TICK, 8'hFF, 1'b1);
    queue_transfer(8'hFF, 1, SDA_HIGH, 1'b1);
    queue_transfer(8'h00, 1, SDA_LOW, 1'b0);
    wait_drained();

    // top address, zero phase length (runs as one)
    junk = 16'($urandom);
    write_reg(CFG_DEV_ADDR, {junk[15:7], 7'h7F});
    write_reg(CFG_PHASE_LEN, 16'h0000);
    queue_transfer(8'($urandom_range(0, 255)), 1, SDA_SPARSE, 1'($urandom_range(0, 1)));
    wait_drained();

    junk = 16'($urandom);
    write_reg(CFG_DEV_ADDR, {junk[15:7], 7'h00});
    write_reg(CFG_PHASE_LEN, 16'd2);
    queue_transfer(8'($urandom_range(0, 255)), 2, SDA_COIN, 1'($urandom_range(0, 1)));
    wait_drained();

    junk = 16'($urandom);
    write_reg(CFG_DEV_ADDR, junk);
    write_reg(CFG_PHASE_LEN, 16'd1);
    queue_transfer(8'($urandom_range(0, 255)), 1, SDA_COIN, 1'($urandom_range(0, 1)));
    wait_drained();

    // longest phase: the sequencer stays in its first phase while ticks count up
    write_reg(CFG_PHASE_LEN, 16'hFFFF);
    push_item(ACT_START, 8'($urandom_range(0, 255)), 1'b0);
    repeat (40) push_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    push_item(ACT_START, 8'($urandom_range(0, 255)), 1'b1);
    wait_drained();

    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/irm_pkg.sv
rtl/irm_step.sv
rtl/i2c_register_read_master.sv
tb/sv/tb.sv
